// File: rtl/cbt_pkg.sv
`default_nettype none

package cbt_pkg;

    localparam int unsigned SAMPLES  = 30;
    localparam int unsigned SAMPLE_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int unsigned COORD_W  = 32;
    localparam int unsigned WEIGHT_W = 17;
    localparam int unsigned PROD_W   = COORD_W + WEIGHT_W + 1;
    localparam int unsigned ACC_W    = PROD_W + 2;
    localparam int unsigned STEP_W   = 4;
    localparam int unsigned STEPS    = 8;
    localparam longint unsigned CubeDen = longint'(SAMPLES) * SAMPLES * SAMPLES;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
    } point_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic                      last_of_run;
    } result_t;

    typedef struct packed {
        logic issue;
        logic acc_en;
        logic acc_first;
        logic acc_y;
    } mac_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMIT_P0,
        ST_EMIT_P3,
        ST_MAC,
        ST_EMIT_PT
    } state_t;

    typedef logic [SAMPLES-1:0][3:0][WEIGHT_W-1:0] weight_table_t;

    // bernstein weights in q1.16, rounded to nearest
    function automatic weight_table_t make_weights();
        weight_table_t   t;
        longint unsigned a;
        longint unsigned u;
        longint unsigned num;
        t = '0;
        for (int j = 0; j < SAMPLES; j++) begin
            a = longint'(j);
            u = longint'(SAMPLES - j);
            for (int k = 0; k < 4; k++) begin
                case (k)
                    0:       num = u * u * u;
                    1:       num = 3 * a * u * u;
                    2:       num = 3 * a * a * u;
                    default: num = a * a * a;
                endcase
                t[j][k] = WEIGHT_W'((num * 65536 + CubeDen / 2) / CubeDen);
            end
        end
        return t;
    endfunction

    localparam weight_table_t WEIGHTS = make_weights();

endpackage

`default_nettype wire

// File: rtl/cbt_mac.sv
`default_nettype none

module cbt_mac (
    input  wire                                  aclk,
    input  cbt_pkg::mac_ctrl_t                   ctrl,
    input  wire logic signed [cbt_pkg::COORD_W-1:0]  coord,
    input  wire logic [cbt_pkg::WEIGHT_W-1:0]    weight,
    output logic signed [cbt_pkg::COORD_W-1:0]   sum_x,
    output logic signed [cbt_pkg::COORD_W-1:0]   sum_y
);

    localparam int unsigned SH_W = cbt_pkg::ACC_W - 16;

    logic signed [cbt_pkg::PROD_W-1:0] prod_reg;
    logic signed [cbt_pkg::ACC_W-1:0]  acc_x_reg;
    logic signed [cbt_pkg::ACC_W-1:0]  acc_y_reg;
    logic signed [cbt_pkg::ACC_W-1:0]  acc_sel;
    logic signed [cbt_pkg::ACC_W-1:0]  acc_next;

    always_ff @(posedge aclk) begin
        if (ctrl.issue) begin
            prod_reg <= cbt_pkg::PROD_W'($signed({coord[cbt_pkg::COORD_W-1], coord})
                        * $signed({1'b0, weight}));
        end
        if (ctrl.acc_en && !ctrl.acc_y) begin
            acc_x_reg <= acc_next;
        end
        if (ctrl.acc_en && ctrl.acc_y) begin
            acc_y_reg <= acc_next;
        end
    end

    always_comb begin
        acc_sel  = ctrl.acc_y ? acc_y_reg : acc_x_reg;
        acc_next = ctrl.acc_first ? cbt_pkg::ACC_W'(prod_reg)
                                  : acc_sel + cbt_pkg::ACC_W'(prod_reg);
    end

    // round half up, then saturate to 32 bits
    function automatic logic signed [cbt_pkg::COORD_W-1:0] round_sat(
        input logic signed [cbt_pkg::ACC_W-1:0] acc
    );
        logic signed [cbt_pkg::ACC_W-1:0] rnd;
        logic signed [SH_W-1:0]           sh;
        logic                             ovf;
        rnd = acc + cbt_pkg::ACC_W'(32768);
        sh  = SH_W'(rnd >>> 16);
        ovf = (sh[SH_W-1:cbt_pkg::COORD_W-1] != '0)
           && (sh[SH_W-1:cbt_pkg::COORD_W-1] != '1);
        if (!ovf) begin
            return sh[cbt_pkg::COORD_W-1:0];
        end else if (sh[SH_W-1]) begin
            return {1'b1, {(cbt_pkg::COORD_W-1){1'b0}}};
        end else begin
            return {1'b0, {(cbt_pkg::COORD_W-1){1'b1}}};
        end
    endfunction

    assign sum_x = round_sat(acc_x_reg);
    assign sum_y = round_sat(acc_y_reg);

endmodule

`default_nettype wire

// File: rtl/cubic_bezier_tessellator.sv
`default_nettype none

// channel   ports                         payload
// input     s_valid / s_ready / s_payload  point_x, point_y (q16.16)
// result    m_valid / m_ready / m_payload  out_x, out_y (q16.16), last_of_run
//
// a point that only gets stored is simply accepted in ST_IDLE
// a segment-completing point starts the sequencer, which emits p0, p3, then SAMPLES points:
// the one 33x18 multiplier runs eight products per sample, then each sum is emitted
// a result waits in the output register; a stall on m_ready holds the sequencer
// synchronous active-low reset clears the sequencer and the point count

module cubic_bezier_tessellator (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_valid,
    output logic                    s_ready,
    input  wire cbt_pkg::point_t    s_payload,
    output logic                    m_valid,
    input  wire                     m_ready,
    output cbt_pkg::result_t        m_payload
);

    cbt_pkg::state_t state_reg, state_next;

    logic                                have_start_reg, have_start_next;
    logic [1:0]                          count_reg, count_next;
    cbt_pkg::point_t                     start_reg, start_next;
    cbt_pkg::point_t                     ctrl_reg [3];
    cbt_pkg::point_t                     ctrl_next [3];
    logic [cbt_pkg::SAMPLE_W-1:0]        j_reg, j_next;
    logic [cbt_pkg::STEP_W-1:0]          step_reg, step_next;
    logic                                m_valid_reg, m_valid_next;
    cbt_pkg::result_t                    m_data_reg, m_data_next;

    logic                                accept;
    logic                                out_free;
    logic                                load_out;
    logic                                last_sample;
    cbt_pkg::result_t                    out_value;
    cbt_pkg::mac_ctrl_t                  mac_ctrl;
    logic [2:0]                          idx;
    logic [2:0]                          acc_idx;
    logic signed [cbt_pkg::COORD_W-1:0]  coord;
    logic [cbt_pkg::WEIGHT_W-1:0]        weight;
    logic signed [cbt_pkg::COORD_W-1:0]  sum_x;
    logic signed [cbt_pkg::COORD_W-1:0]  sum_y;
    cbt_pkg::point_t                     pt_sel;

    assign accept      = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign last_sample = (j_reg == cbt_pkg::SAMPLE_W'(cbt_pkg::SAMPLES - 1));
    assign idx         = step_reg[2:0];
    assign acc_idx     = idx - 3'd1;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cbt_pkg::ST_IDLE: begin
                if (accept && have_start_reg && count_reg[1]) begin
                    state_next = cbt_pkg::ST_EMIT_P0;
                end
            end
            cbt_pkg::ST_EMIT_P0: begin
                if (out_free) begin
                    state_next = cbt_pkg::ST_EMIT_P3;
                end
            end
            cbt_pkg::ST_EMIT_P3: begin
                if (out_free) begin
                    state_next = cbt_pkg::ST_MAC;
                end
            end
            cbt_pkg::ST_MAC: begin
                if (step_reg == cbt_pkg::STEP_W'(cbt_pkg::STEPS)) begin
                    state_next = cbt_pkg::ST_EMIT_PT;
                end
            end
            cbt_pkg::ST_EMIT_PT: begin
                if (out_free) begin
                    state_next = last_sample ? cbt_pkg::ST_IDLE : cbt_pkg::ST_MAC;
                end
            end
            default: state_next = cbt_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_ready   = 1'b0;
        load_out  = 1'b0;
        out_value = '0;
        mac_ctrl  = '0;
        case (state_reg)
            cbt_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            cbt_pkg::ST_EMIT_P0: begin
                load_out  = out_free;
                out_value = '{out_x: start_reg.point_x, out_y: start_reg.point_y,
                              last_of_run: 1'b0};
            end
            cbt_pkg::ST_EMIT_P3: begin
                load_out  = out_free;
                out_value = '{out_x: ctrl_reg[2].point_x, out_y: ctrl_reg[2].point_y,
                              last_of_run: 1'b0};
            end
            cbt_pkg::ST_MAC: begin
                mac_ctrl.issue     = !step_reg[3];
                mac_ctrl.acc_en    = (step_reg != '0);
                mac_ctrl.acc_first = (acc_idx[1:0] == 2'd0);
                mac_ctrl.acc_y     = acc_idx[2];
            end
            cbt_pkg::ST_EMIT_PT: begin
                load_out  = out_free;
                out_value = '{out_x: sum_x, out_y: sum_y, last_of_run: last_sample};
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // operand select for the shared multiplier
    always_comb begin
        case (idx[1:0])
            2'd0:    pt_sel = start_reg;
            2'd1:    pt_sel = ctrl_reg[0];
            2'd2:    pt_sel = ctrl_reg[1];
            default: pt_sel = ctrl_reg[2];
        endcase
        coord  = idx[2] ? pt_sel.point_y : pt_sel.point_x;
        weight = cbt_pkg::WEIGHTS[j_reg][idx[1:0]];
    end

    // datapath next values
    always_comb begin
        have_start_next = have_start_reg;
        count_next      = count_reg;
        start_next      = start_reg;
        ctrl_next       = ctrl_reg;
        j_next          = j_reg;
        step_next       = '0;
        m_data_next     = m_data_reg;
        m_valid_next    = m_valid_reg && !m_ready;

        if (load_out) begin
            m_data_next  = out_value;
            m_valid_next = 1'b1;
        end

        if (accept) begin
            if (!have_start_reg) begin
                start_next      = s_payload;
                have_start_next = 1'b1;
            end else if (!count_reg[1]) begin
                ctrl_next[{1'b0, count_reg[0]}] = s_payload;
                count_next                      = count_reg + 2'd1;
            end else begin
                ctrl_next[2] = s_payload;
            end
        end

        if (state_reg == cbt_pkg::ST_EMIT_P3) begin
            j_next = '0;
        end

        if (state_reg == cbt_pkg::ST_MAC && step_reg != cbt_pkg::STEP_W'(cbt_pkg::STEPS)) begin
            step_next = step_reg + cbt_pkg::STEP_W'(1);
        end

        if (state_reg == cbt_pkg::ST_EMIT_PT && out_free) begin
            j_next = j_reg + cbt_pkg::SAMPLE_W'(1);
            if (last_sample) begin
                start_next = ctrl_reg[2];
                count_next = 2'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= cbt_pkg::ST_IDLE;
            have_start_reg <= 1'b0;
            count_reg      <= 2'd0;
            step_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            have_start_reg <= have_start_next;
            count_reg      <= count_next;
            step_reg       <= step_next;
            m_valid_reg    <= m_valid_next;
        end
        start_reg  <= start_next;
        ctrl_reg   <= ctrl_next;
        j_reg      <= j_next;
        m_data_reg <= m_data_next;
    end

    cbt_mac u_mac (
        .aclk   (aclk),
        .ctrl   (mac_ctrl),
        .coord  (coord),
        .weight (weight),
        .sum_x  (sum_x),
        .sum_y  (sum_y)
    );

    assign m_valid   = m_valid_reg;
    assign m_payload = m_data_reg;

endmodule

`default_nettype wire

// File: sim/cubic_bezier_tessellator_checker.sv
`timescale 1ns / 100ps

module cubic_bezier_tessellator_checker (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       s_valid,
    input  wire                       s_ready,
    input  wire cbt_pkg::point_t      s_payload,
    input  wire                       m_valid,
    input  wire                       m_ready,
    input  wire cbt_pkg::result_t     m_payload,
    output int                        pending_results,
    output int                        fail_count
);

    localparam longint CoordMax   = 2147483647;
    localparam longint CoordMin   = -longint'(2147483647) - 1;

    cbt_pkg::result_t    curve_q[$];
    logic signed [31:0]  start_x;
    logic signed [31:0]  start_y;
    logic signed [31:0]  ctrl_x[3];
    logic signed [31:0]  ctrl_y[3];
    logic [1:0]          ctrl_count;
    logic                have_p0;
    int                  mismatches;

    assign fail_count = mismatches;

    // bernstein weight k at sample j, unsigned q1.16, halves up
    function automatic longint bern_weight(input int j, input int k);
        longint num;
        longint a;
        longint u;
        longint den;
        a   = j;
        u   = cbt_pkg::SAMPLES - j;
        den = longint'(cbt_pkg::SAMPLES) * cbt_pkg::SAMPLES * cbt_pkg::SAMPLES;
        case (k)
            0:       num = u * u * u;
            1:       num = 3 * a * u * u;
            2:       num = 3 * a * a * u;
            default: num = a * a * a;
        endcase
        return (num * 65536 + den / 2) / den;
    endfunction

    function automatic logic signed [31:0] curve_coord(input longint c0, input longint c1,
                                                       input longint c2, input longint c3,
                                                       input int j);
        longint sum;
        sum = c0 * bern_weight(j, 0) + c1 * bern_weight(j, 1)
            + c2 * bern_weight(j, 2) + c3 * bern_weight(j, 3);
        sum = (sum + 32768) >>> 16;
        if (sum > CoordMax) begin
            sum = CoordMax;
        end else if (sum < CoordMin) begin
            sum = CoordMin;
        end
        return sum[31:0];
    endfunction

    task automatic push_point(input logic signed [31:0] x, input logic signed [31:0] y,
                              input logic last);
        cbt_pkg::result_t r;
        r.out_x       = x;
        r.out_y       = y;
        r.last_of_run = last;
        curve_q = {curve_q, r};
    endtask

    task automatic absorb_point(input cbt_pkg::point_t pt);
        if (!have_p0) begin
            start_x = pt.point_x;
            start_y = pt.point_y;
            have_p0 = 1'b1;
        end else if (ctrl_count < 2) begin
            ctrl_x[ctrl_count] = pt.point_x;
            ctrl_y[ctrl_count] = pt.point_y;
            ctrl_count++;
        end else begin
            // segment complete: p0, p3, then the samples
            ctrl_x[2] = pt.point_x;
            ctrl_y[2] = pt.point_y;
            push_point(start_x, start_y, 1'b0);
            push_point(ctrl_x[2], ctrl_y[2], 1'b0);
            for (int j = 0; j < cbt_pkg::SAMPLES; j++) begin
                push_point(curve_coord(start_x, ctrl_x[0], ctrl_x[1], ctrl_x[2], j),
                           curve_coord(start_y, ctrl_y[0], ctrl_y[1], ctrl_y[2], j),
                           j == cbt_pkg::SAMPLES - 1);
            end
            start_x    = ctrl_x[2];
            start_y    = ctrl_y[2];
            ctrl_count = '0;
        end
    endtask

    task automatic check_result(input cbt_pkg::result_t got);
        cbt_pkg::result_t want;
        if (curve_q.size() == 0) begin
            mismatches++;
            $display("%0t: expected no result, got x=%h y=%h last=%b", $time,
                     got.out_x, got.out_y, got.last_of_run);
        end else begin
            want = curve_q.pop_front();
            if (got.out_x !== want.out_x || got.out_y !== want.out_y
                    || got.last_of_run !== want.last_of_run) begin
                mismatches++;
                $display("%0t: expected x=%h y=%h last=%b, got x=%h y=%h last=%b",
                         $time, want.out_x, want.out_y, want.last_of_run,
                         got.out_x, got.out_y, got.last_of_run);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            curve_q.delete();
            start_x    = '0;
            start_y    = '0;
            ctrl_count = '0;
            have_p0    = 1'b0;
            for (int k = 0; k < 3; k++) begin
                ctrl_x[k] = '0;
                ctrl_y[k] = '0;
            end
        end else begin
            if (s_valid && s_ready) begin
                absorb_point(s_payload);
            end
            if (m_valid && m_ready) begin
                check_result(m_payload);
            end
        end
        pending_results <= curve_q.size();
    end

endmodule

// File: sim/cubic_bezier_tessellator_tb.sv
`timescale 1ns / 100ps

module cubic_bezier_tessellator_tb;

    localparam int RandomPoints = 250;
    localparam int QuietPoints  = 40;
    localparam int DrainPoint   = 117;
    localparam int TailCycles   = 400;
    localparam int StallLimit   = 4000;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    cbt_pkg::point_t  s_payload;
    logic             m_valid;
    logic             m_ready;
    cbt_pkg::result_t m_payload;

    int      pending_results;
    int      fail_count;
    int      stall_cycles = 0;
    int      gap_pct = 30;
    bit      quiet = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    cubic_bezier_tessellator u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    cubic_bezier_tessellator_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_payload       (s_payload),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_payload       (m_payload),
        .pending_results (pending_results),
        .fail_count      (fail_count)
    );

    function automatic cbt_pkg::point_t mk_point(input logic [31:0] x, input logic [31:0] y);
        cbt_pkg::point_t pt;
        pt.point_x = x;
        pt.point_y = y;
        return pt;
    endfunction

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 9))
            0:       return 32'h7fffffff;
            1:       return 32'h80000000;
            2:       return 32'($urandom_range(0, 2097151)) - 32'd1048576;
            3:       return {16'($urandom_range(0, 3)) - 16'd2, 16'h8000};
            4:       return 32'h7fff0000 + 32'($urandom_range(0, 65535));
            5:       return 32'h80000000 + 32'($urandom_range(0, 65535));
            default: return $urandom();
        endcase
    endfunction

    task automatic send_point(input cbt_pkg::point_t pt);
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_payload <= pt;
        s_valid   <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
    endtask

    // result side back-pressure
    initial begin
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            repeat (($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(1, 12)) @(posedge aclk);
            if (!quiet && $urandom_range(0, 3) != 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        @(posedge aclk);
        while (stall_cycles < StallLimit) @(posedge aclk);
        $display("cubic_bezier_tessellator_tb failed");
        $finish;
    end

    initial begin
        s_valid   = 1'b0;
        s_payload = '0;
        aresetn   = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // first point only sets the segment start
        send_point(mk_point(32'h00000000, 32'h00000000));
        send_point(mk_point(32'h00000001, 32'hffffffff));
        send_point(mk_point(32'hffffffff, 32'h00000001));
        send_point(mk_point(32'h7fffffff, 32'h80000000));
        // all four points at opposite extremes, sums go past range
        send_point(mk_point(32'h7fffffff, 32'h80000000));
        send_point(mk_point(32'h7fffffff, 32'h80000000));
        send_point(mk_point(32'h7fffffff, 32'h80000000));
        send_point(mk_point(32'h80000000, 32'h7fffffff));
        send_point(mk_point(32'h80000000, 32'h7fffffff));
        send_point(mk_point(32'h80000000, 32'h7fffffff));
        send_point(mk_point(32'h80000000, 32'h7fffffff));
        send_point(mk_point(32'h80000000, 32'h7fffffff));
        send_point(mk_point(32'h80000000, 32'h7fffffff));
        // rounding around half lsb
        send_point(mk_point(32'h00008000, 32'hffff8000));
        send_point(mk_point(32'hffff8000, 32'h00008000));
        send_point(mk_point(32'h00007fff, 32'hffff7fff));
        send_point(mk_point(32'h55555555, 32'haaaaaaaa));
        send_point(mk_point(32'haaaaaaaa, 32'h55555555));
        send_point(mk_point(32'h00000000, 32'h00000000));
        wait_drained();

        for (int i = 0; i < RandomPoints; i++) begin
            if (i % 25 == 0) begin
                case ($urandom_range(0, 2))
                    0:       gap_pct = 0;
                    1:       gap_pct = 20;
                    default: gap_pct = 60;
                endcase
            end
            if (i == RandomPoints - QuietPoints) begin
                quiet = 1'b1;
            end
            if (i == DrainPoint) begin
                wait_drained();
            end
            send_point(mk_point(pick_coord(), pick_coord()));
        end
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (TailCycles) @(posedge aclk);

        if (fail_count == 0 && pending_results == 0) begin
            $display("cubic_bezier_tessellator_tb passed");
        end else begin
            $display("cubic_bezier_tessellator_tb failed");
        end
        $finish;
    end

endmodule
